// ===== sv/lsm_pkg.sv =====
package lsm_pkg;

	localparam int IDX_W    = 6;
	localparam int TOTAL_W  = 7;
	localparam int LIMIT_W  = 7;
	localparam int STATUS_W = 3;

	localparam logic [1:0] CMD_REGISTER   = 2'd0;
	localparam logic [1:0] CMD_UNREGISTER = 2'd1;
	localparam logic [1:0] CMD_USE        = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_OPEN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_EVICT = 3'd4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd20;

	typedef struct packed {
		logic [1:0]       command;
		logic [IDX_W-1:0] slot_index;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    assigned_index;
		logic                evicted_valid;
		logic [IDX_W-1:0]    evicted_index;
		logic [TOTAL_W-1:0]  open_total;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== sv/lru_open_slot_manager.sv =====
// Least-recently-used slot manager. Each command transaction returns exactly one
// result transaction. A register command that must evict walks the stamps of all
// slots handed out so far through the single read port of the stamp memory, one
// slot per cycle. A new command is taken while the previous result still waits
// in the output register. The limit may be written only while no command is
// in flight.
module lru_open_slot_manager #(
	parameter int SLOTS = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lsm_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lsm_pkg::out_item_t          out_data,
	input  logic                        cfg_wr_en,
	input  logic [lsm_pkg::LIMIT_W-1:0] cfg_wr_data
);
	import lsm_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	lsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	lsm_datapath #(
		.SLOTS     (SLOTS),
		.STAMP_BITS(STAMP_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== sv/lsm_ram.sv =====
module lsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/lsm_ctrl.sv =====
module lsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsm_pkg::dp_stat_t stat,
	output lsm_pkg::ctl_cmd_t cmd
);
	import lsm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.start = in_valid && (state_q == S_IDLE);
	assign cmd.scan  = (state_q == S_SCAN);
	assign cmd.exec  = (state_q == S_EXEC) && stat.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/lsm_datapath.sv =====
module lsm_datapath #(
	parameter int SLOTS = 64,
	parameter int STAMP_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsm_pkg::in_item_t               in_data,
	input  logic                            cfg_wr_en,
	input  logic [lsm_pkg::LIMIT_W-1:0]     cfg_wr_data,
	input  lsm_pkg::ctl_cmd_t               cmd,
	output lsm_pkg::dp_stat_t               stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lsm_pkg::out_item_t              out_data
);
	import lsm_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int IW = $clog2(SLOTS + 1);
	localparam int CW = ((IW > LIMIT_W) ? IW : LIMIT_W) + 1;
	localparam int CW_IDX = (CW > IDX_W) ? CW : IDX_W;

	logic [1:0]            cmd_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IW-1:0]         scan_q;
	logic                  rd_valid_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic                  found_q;
	logic [STAMP_BITS-1:0] best_q;
	logic [AW-1:0]         victim_q;
	logic [SLOTS-1:0]      open_q;
	logic [IW-1:0]         issued_q;
	logic [IW-1:0]         count_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [LIMIT_W-1:0]    limit_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic [STAMP_BITS-1:0] rd_data;
	logic                  need_evict;
	logic                  needs_scan;
	logic                  scan_rd;
	logic                  idx_bad;
	logic [AW-1:0]         sidx;
	logic                  table_full;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic                  do_evict;
	logic                  do_assign;
	logic                  do_close;
	logic [IW-1:0]         count_d;
	logic [SLOTS-1:0]      open_d;
	out_item_t             res;

	assign need_evict = (CW'(count_q) + CW'(1)) >= CW'(limit_q);
	assign needs_scan = (cmd_q == CMD_REGISTER) && need_evict;
	assign scan_rd    = cmd.scan && needs_scan && (scan_q < issued_q);
	assign idx_bad    = CW_IDX'(idx_q) >= CW_IDX'(issued_q);
	assign sidx       = AW'(idx_q);
	assign table_full = issued_q >= IW'(SLOTS);

	assign stat.scan_done = !needs_scan || (!(scan_q < issued_q) && !rd_valid_s1);
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	always_comb begin
		res       = '0;
		do_evict  = 1'b0;
		do_assign = 1'b0;
		do_close  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = AW'(issued_q);
		count_d   = count_q;
		open_d    = open_q;
		case (cmd_q)
			CMD_REGISTER: begin
				if (need_evict && !found_q) begin
					res.status = ST_NO_EVICT;
				end else begin
					if (need_evict) begin
						do_evict          = 1'b1;
						res.evicted_valid = 1'b1;
						res.evicted_index = IDX_W'(victim_q);
					end
					if (table_full) begin
						res.status = ST_FULL;
					end else begin
						do_assign          = 1'b1;
						ram_we             = 1'b1;
						res.assigned_index = IDX_W'(issued_q);
					end
				end
				count_d = count_q - IW'(do_evict) + IW'(do_assign);
			end
			CMD_UNREGISTER: begin
				if (idx_bad) begin
					res.status = ST_BAD_IDX;
				end else if (!open_q[sidx]) begin
					res.status = ST_NOT_OPEN;
				end else begin
					do_close = 1'b1;
					count_d  = count_q - IW'(1);
				end
			end
			CMD_USE: begin
				if (idx_bad) begin
					res.status = ST_BAD_IDX;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = sidx;
				end
			end
			default: ;
		endcase
		if (do_evict) begin
			open_d[victim_q] = 1'b0;
		end
		if (do_close) begin
			open_d[sidx] = 1'b0;
		end
		if (do_assign) begin
			open_d[AW'(issued_q)] = 1'b1;
		end
		res.open_total = TOTAL_W'(count_d);
	end

	lsm_ram #(
		.WIDTH(STAMP_BITS),
		.DEPTH(SLOTS)
	) u_stamp_ram (
		.clk    (clk),
		.wr_en  (cmd.exec && ram_we),
		.wr_addr(ram_waddr),
		.wr_data(stamp_q),
		.rd_en  (scan_rd),
		.rd_addr(AW'(scan_q)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q <= in_data.command;
			idx_q <= in_data.slot_index;
		end
		rd_idx_s1 <= AW'(scan_q);
		if (cmd.exec) begin
			out_q <= res;
		end
		if (rd_valid_s1 && open_q[rd_idx_s1] && (!found_q || rd_data < best_q)) begin
			best_q   <= rd_data;
			victim_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			open_q      <= '0;
			issued_q    <= '0;
			count_q     <= '0;
			stamp_q     <= STAMP_BITS'(1);
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			rd_valid_s1 <= scan_rd;
			if (cmd.start) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (scan_rd) begin
					scan_q <= scan_q + IW'(1);
				end
				if (rd_valid_s1 && open_q[rd_idx_s1]) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
				open_q      <= open_d;
				if (ram_we) begin
					stamp_q <= stamp_q + STAMP_BITS'(1);
				end
				if (do_assign) begin
					issued_q <= issued_q + IW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/lsm_reply_checker.sv =====
`timescale 1ns / 1ps

module lsm_reply_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  lsm_pkg::in_item_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  lsm_pkg::out_item_t          out_data,
	input  logic                        cfg_wr_en,
	input  logic [lsm_pkg::LIMIT_W-1:0] cfg_wr_data,
	output int                          mismatch_count,
	output int                          pending_replies,
	output int                          replies_checked,
	output int                          evictions_seen,
	output int                          full_seen,
	output int                          no_victim_seen
);

	import lsm_pkg::*;

	localparam int SLOTS = 64;

	logic [SLOTS-1:0] slot_is_open;
	logic [31:0]      slot_last_use [SLOTS];
	int               issued_slots;
	int               open_slots;
	logic [31:0]      use_counter;
	int               limit_value;
	out_item_t        awaited_replies [$];

	function automatic out_item_t apply_slot_command(in_item_t item);
		out_item_t reply;
		logic      proceed;
		logic      found;
		int        victim;
		logic [31:0] oldest;
		reply = '0;
		proceed = 1'b1;
		found = 1'b0;
		victim = 0;
		oldest = '0;
		case (item.command)
			CMD_REGISTER: begin
				if (open_slots + 1 >= limit_value) begin
					for (int i = 0; i < issued_slots; i++) begin
						if (slot_is_open[i] && (!found || slot_last_use[i] < oldest)) begin
							found = 1'b1;
							oldest = slot_last_use[i];
							victim = i;
						end
					end
					if (found) begin
						slot_is_open[victim] = 1'b0;
						open_slots--;
						reply.evicted_valid = 1'b1;
						reply.evicted_index = victim[IDX_W-1:0];
					end else begin
						reply.status = ST_NO_EVICT;
						proceed = 1'b0;
					end
				end
				if (proceed) begin
					if (issued_slots >= SLOTS) begin
						reply.status = ST_FULL;
					end else begin
						reply.assigned_index = issued_slots[IDX_W-1:0];
						slot_is_open[issued_slots] = 1'b1;
						slot_last_use[issued_slots] = use_counter;
						issued_slots++;
						open_slots++;
						use_counter = use_counter + 32'd1;
					end
				end
			end
			CMD_UNREGISTER: begin
				if (item.slot_index >= issued_slots) begin
					reply.status = ST_BAD_IDX;
				end else if (!slot_is_open[item.slot_index]) begin
					reply.status = ST_NOT_OPEN;
				end else begin
					slot_is_open[item.slot_index] = 1'b0;
					open_slots--;
				end
			end
			CMD_USE: begin
				if (item.slot_index >= issued_slots) begin
					reply.status = ST_BAD_IDX;
				end else begin
					slot_last_use[item.slot_index] = use_counter;
					use_counter = use_counter + 32'd1;
				end
			end
			default: begin
			end
		endcase
		reply.open_total = open_slots[TOTAL_W-1:0];
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			slot_is_open = '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_last_use[i] = '0;
			end
			issued_slots = 0;
			open_slots = 0;
			use_counter = 32'd1;
			limit_value = int'(LIMIT_RESET);
			awaited_replies.delete();
			mismatch_count = 0;
			pending_replies = 0;
			replies_checked = 0;
			evictions_seen = 0;
			full_seen = 0;
			no_victim_seen = 0;
		end else begin
			if (cfg_wr_en) begin
				limit_value = int'(cfg_wr_data);
			end
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Unexpected reply: status %0d assigned %0d evicted %0d/%0d open %0d",
							out_data.status, out_data.assigned_index, out_data.evicted_valid,
							out_data.evicted_index, out_data.open_total);
					end
				end else begin
					want = awaited_replies.pop_front();
					replies_checked++;
					if (want.evicted_valid) begin
						evictions_seen++;
					end
					if (want.status == ST_FULL) begin
						full_seen++;
					end
					if (want.status == ST_NO_EVICT) begin
						no_victim_seen++;
					end
					if (out_data.status !== want.status
						|| out_data.assigned_index !== want.assigned_index
						|| out_data.evicted_valid !== want.evicted_valid
						|| out_data.evicted_index !== want.evicted_index
						|| out_data.open_total !== want.open_total) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("Reply %0d mismatch: expected status %0d assigned %0d",
								replies_checked, want.status, want.assigned_index);
							$display("  evicted %0d/%0d open %0d; got status %0d assigned %0d",
								want.evicted_valid, want.evicted_index, want.open_total,
								out_data.status, out_data.assigned_index);
							$display("  evicted %0d/%0d open %0d",
								out_data.evicted_valid, out_data.evicted_index,
								out_data.open_total);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				awaited_replies.insert(awaited_replies.size(), apply_slot_command(in_data));
			end
			pending_replies = awaited_replies.size();
		end
	end

endmodule

// ===== tb/tb_lru_open_slot_manager.sv =====
`timescale 1ns / 1ps

module tb_lru_open_slot_manager;

	import lsm_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 128;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_PHASE = 3;
	localparam longint TIMEOUT_NS = 64'd6_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_data;
	logic               cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0] cfg_wr_data = '0;

	logic calm = 1'b0;
	logic hold_armed = 1'b0;
	int   issued_guess = 0;
	int   limit_writes = 0;

	int mismatch_count;
	int pending_replies;
	int replies_checked;
	int evictions_seen;
	int full_seen;
	int no_victim_seen;

	int phase_limit [PHASES] = '{5, 127, 2, 20, 1, 64, 10, 0, 65, 3};

	always #5 clk = ~clk;

	lru_open_slot_manager uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	lsm_reply_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mismatch_count (mismatch_count),
		.pending_replies(pending_replies),
		.replies_checked(replies_checked),
		.evictions_seen (evictions_seen),
		.full_seen      (full_seen),
		.no_victim_seen (no_victim_seen)
	);

	task automatic offer(input logic [1:0] cmd, input logic [IDX_W-1:0] idx);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, slot_index: idx};
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (cmd == CMD_REGISTER && issued_guess < 64) begin
			issued_guess++;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input int value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[LIMIT_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_writes++;
	endtask

	task automatic offer_random();
		int pick;
		logic [1:0] cmd;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(99);
		if (pick < 9) begin
			cmd = CMD_REGISTER;
		end else if (pick < 16) begin
			cmd = CMD_UNREGISTER;
		end else if (pick < 95) begin
			cmd = CMD_USE;
		end else begin
			cmd = CMD_UNKNOWN;
		end
		if (issued_guess > 0 && $urandom_range(99) < 85) begin
			idx = IDX_W'($urandom_range(issued_guess - 1));
		end else begin
			idx = IDX_W'($urandom_range(63));
		end
		offer(cmd, idx);
	endtask

	// The receiver stalls at random, except during the calm phase, and once
	// refuses results for a long stretch so that the block backs up.
	initial begin : result_sink
		int hold_left;
		logic hold_spent;
		hold_left = 0;
		hold_spent = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_spent) begin
				hold_spent = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: bad indexes and the ignored command; then registers, and uses and unregisters of the new slots.
		offer(CMD_UNREGISTER, 6'd0);
		offer(CMD_USE, 6'd63);
		offer(CMD_UNKNOWN, 6'd63);
		offer(CMD_UNKNOWN, 6'd0);
		offer(CMD_REGISTER, 6'd0);
		offer(CMD_REGISTER, 6'd63);
		offer(CMD_REGISTER, 6'd21);
		offer(CMD_USE, 6'd0);
		offer(CMD_UNREGISTER, 6'd1);
		offer(CMD_UNREGISTER, 6'd1);
		offer(CMD_USE, 6'd1);
		offer(CMD_UNREGISTER, 6'd5);

		// A limit of one forces eviction on every register, and with
		// nothing open the register is refused.
		write_limit(1);
		offer(CMD_REGISTER, 6'd42);
		offer(CMD_UNREGISTER, 6'd0);
		offer(CMD_UNREGISTER, 6'd1);
		offer(CMD_UNREGISTER, 6'd2);
		offer(CMD_UNREGISTER, 6'd3);
		offer(CMD_REGISTER, 6'd0);

		for (int p = 0; p < PHASES; p++) begin
			write_limit(phase_limit[p]);
			calm <= (p == CALM_PHASE);
			if (p == 1) begin
				hold_armed <= 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer_random();
			end
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Run covered %0d commands over %0d limit settings from 0 to 127,",
			replies_checked, limit_writes);
		$display("with %0d evictions, %0d table-full and %0d nothing-to-evict replies.",
			evictions_seen, full_seen, no_victim_seen);
		if (mismatch_count == 0 && pending_replies == 0) begin
			$display("[lru_open_slot_manager] OK");
		end else begin
			$display("[lru_open_slot_manager] ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timed out with %0d replies outstanding.", pending_replies);
		$display("[lru_open_slot_manager] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lsm_pkg.sv
sv/lsm_ram.sv
sv/lsm_ctrl.sv
sv/lsm_datapath.sv
sv/lru_open_slot_manager.sv
tb/lsm_reply_checker.sv
tb/tb_lru_open_slot_manager.sv
